FILE: design/lcct_pkg.sv
// shared types and constants for the linear classifier confusion tally
package lcct_pkg;

	localparam int COORD_W   = 16;
	localparam int WEIGHT_W  = 16;
	localparam int PROD_W    = COORD_W + WEIGHT_W;
	localparam int BIAS_W    = 36;
	localparam int MARGIN_W  = 32;
	localparam int D_W       = 38;
	localparam int MAX_DIM   = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 36;
	localparam int CNT_OUT_W = 16;
	localparam int ERR_W     = 17;
	localparam int ACC_W     = 18;

	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_A = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_B = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_C = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_D = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MARGIN   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT   = 3'd6;

	localparam logic [MARGIN_W-1:0] MARGIN_RESET = 32'd42;

	localparam logic [1:0] CLS_POS  = 2'd0;
	localparam logic [1:0] CLS_NEG  = 2'd1;
	localparam logic [1:0] CLS_ZERO = 2'd2;

	typedef struct packed {
		logic signed [COORD_W-1:0] coord_a;
		logic signed [COORD_W-1:0] coord_b;
		logic signed [COORD_W-1:0] coord_c;
		logic signed [COORD_W-1:0] coord_d;
		logic [1:0]                ground_label;
		logic                      first_of_set;
	} point_t;

	typedef struct packed {
		logic [1:0]           predicted;
		logic [CNT_OUT_W-1:0] true_pos;
		logic [CNT_OUT_W-1:0] false_pos;
		logic [CNT_OUT_W-1:0] false_neg;
		logic [CNT_OUT_W-1:0] true_neg;
		logic [CNT_OUT_W-1:0] unknown;
		logic [ERR_W-1:0]     error_total;
		logic [ACC_W-1:0]     accurate_total;
	} result_t;

	// sideband that rides along the pipeline with each point
	typedef struct packed {
		logic [1:0] ground_label;
		logic       first_of_set;
	} side_t;

endpackage

FILE: design/lcct_lane.sv
// one multiply lane: coordinate times normal component, registered
module lcct_lane (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [lcct_pkg::COORD_W-1:0]  coord,
	input  logic signed [lcct_pkg::WEIGHT_W-1:0] weight,
	output logic signed [lcct_pkg::PROD_W-1:0]   prod_s1
);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= coord * weight;
		end
	end

endmodule

FILE: design/lcct_merge.sv
// lane merge: sum of products minus bias, then dead band compare
module lcct_merge #(
	parameter int DIM = 4
) (
	input  logic                                  clk,
	input  logic                                  en_s2,
	input  logic                                  en_s3,
	input  logic signed [lcct_pkg::PROD_W-1:0]    prod_s1 [DIM],
	input  lcct_pkg::side_t                       side_s1,
	input  logic signed [lcct_pkg::BIAS_W-1:0]    bias,
	input  logic        [lcct_pkg::MARGIN_W-1:0]  margin,
	input  logic                                  invert,
	output logic        [1:0]                     pred_s3,
	output lcct_pkg::side_t                       side_s3
);

	logic signed [lcct_pkg::D_W-1:0] acc;
	logic signed [lcct_pkg::D_W-1:0] d_s2;
	lcct_pkg::side_t                 side_s2;
	logic signed [lcct_pkg::D_W-1:0] mar_p;
	logic signed [lcct_pkg::D_W-1:0] mar_n;
	logic                            above;
	logic                            below;
	logic [1:0]                      pred;

	always_comb begin
		acc = lcct_pkg::D_W'(bias);
		acc = -acc;
		for (int i = 0; i < DIM; i++) begin
			acc = acc + lcct_pkg::D_W'(prod_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			d_s2    <= acc;
			side_s2 <= side_s1;
		end
	end

	// inverting d is the same as swapping the two sides of the band
	always_comb begin
		mar_p = lcct_pkg::D_W'($signed({1'b0, margin}));
		mar_n = -mar_p;
		above = d_s2 > mar_p;
		below = d_s2 < mar_n;
		if (invert ? below : above) begin
			pred = lcct_pkg::CLS_POS;
		end else if (invert ? above : below) begin
			pred = lcct_pkg::CLS_NEG;
		end else begin
			pred = lcct_pkg::CLS_ZERO;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			pred_s3 <= pred;
			side_s3 <= side_s2;
		end
	end

endmodule

FILE: design/lcct_tally.sv
// saturating confusion counters and the result register
module lcct_tally #(
	parameter int COUNT_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              count_en,
	input  logic [1:0]        pred,
	input  lcct_pkg::side_t   side,
	output lcct_pkg::result_t res_q
);

	localparam int TOT_W = (COUNT_BITS + 2 > lcct_pkg::ACC_W) ? COUNT_BITS + 2
		: lcct_pkg::ACC_W;

	logic [COUNT_BITS-1:0] tp_q, fp_q, fn_q, tn_q, un_q;
	logic [COUNT_BITS-1:0] tp_n, fp_n, fn_n, tn_n, un_n;
	logic [TOT_W-1:0]      err_sum, acc_sum;
	logic                  gpos, gneg;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
		return (&c) ? c : c + 1'b1;
	endfunction

	always_comb begin
		gpos = side.ground_label == lcct_pkg::CLS_POS;
		gneg = side.ground_label == lcct_pkg::CLS_NEG;
		if (side.first_of_set) begin
			tp_n = '0; fp_n = '0; fn_n = '0; tn_n = '0; un_n = '0;
		end else begin
			tp_n = tp_q; fp_n = fp_q; fn_n = fn_q; tn_n = tn_q; un_n = un_q;
		end
		if (pred == lcct_pkg::CLS_POS && gpos) begin
			tp_n = sat_inc(tp_n);
		end else if (pred == lcct_pkg::CLS_POS && gneg) begin
			fp_n = sat_inc(fp_n);
		end else if (pred == lcct_pkg::CLS_NEG && gpos) begin
			fn_n = sat_inc(fn_n);
		end else if (pred == lcct_pkg::CLS_NEG && gneg) begin
			tn_n = sat_inc(tn_n);
		end else begin
			un_n = sat_inc(un_n);
		end
		err_sum = TOT_W'(fp_n) + TOT_W'(fn_n);
		acc_sum = TOT_W'(tp_n) + TOT_W'(tn_n) + TOT_W'(un_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tp_q <= '0;
			fp_q <= '0;
			fn_q <= '0;
			tn_q <= '0;
			un_q <= '0;
		end else if (count_en) begin
			tp_q <= tp_n;
			fp_q <= fp_n;
			fn_q <= fn_n;
			tn_q <= tn_n;
			un_q <= un_n;
		end
	end

	always_ff @(posedge clk) begin
		if (count_en) begin
			res_q.predicted      <= pred;
			res_q.true_pos       <= lcct_pkg::CNT_OUT_W'(tp_n);
			res_q.false_pos      <= lcct_pkg::CNT_OUT_W'(fp_n);
			res_q.false_neg      <= lcct_pkg::CNT_OUT_W'(fn_n);
			res_q.true_neg       <= lcct_pkg::CNT_OUT_W'(tn_n);
			res_q.unknown        <= lcct_pkg::CNT_OUT_W'(un_n);
			res_q.error_total    <= err_sum[lcct_pkg::ERR_W-1:0];
			res_q.accurate_total <= acc_sum[lcct_pkg::ACC_W-1:0];
		end
	end

endmodule

FILE: design/linear_classifier_confusion_tally.sv
// top level of the streaming linear classifier with confusion tallies
//
// Each point item carries DIM signed Q8.8 coordinates, its true class and a
// first_of_set flag. The block forms d = sum(coord_i * weight_i) - bias in
// Q22 scale, optionally negated by invert, and predicts positive above
// +margin, negative below -margin and zero inside the band (edges included).
// Five saturating tallies (tp, fp, fn, tn, unknown) are updated per point and
// every point yields exactly one result item with the class, the tallies after
// this point, fp+fn and tp+tn+unknown. A first_of_set point clears the tallies
// before it is counted. Throughput is one point per clock unless res_ready
// stalls the result. The accepting edge loads the multiply lane products,
// then the sum-and-bias adder register, the band compare register and the
// counter update take the point in that order; the counter update loads the
// result and raises res_valid. The counter update is the only loop. Each
// stage holds independently, so bubbles fill while the result waits.
// Configuration is written through wr_en/wr_index/wr_data while idle; the
// user must keep to this, as the block itself does not enforce it.
module linear_classifier_confusion_tally #(
	parameter int DIM        = 4,
	parameter int COUNT_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               wr_en,
	input  logic [lcct_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [lcct_pkg::CFG_DAT_W-1:0]     wr_data,
	// point channel
	input  logic                               pt_valid,
	output logic                               pt_ready,
	input  lcct_pkg::point_t                   pt,
	// result channel
	output logic                               res_valid,
	input  logic                               res_ready,
	output lcct_pkg::result_t                  res
);

	// configuration registers
	logic signed [lcct_pkg::WEIGHT_W-1:0] weight_q [DIM];
	logic signed [lcct_pkg::BIAS_W-1:0]   bias_q;
	logic        [lcct_pkg::MARGIN_W-1:0] margin_q;
	logic                                 invert_q;

	// pipeline valids and stage enables
	logic v_s1, v_s2, v_s3, res_valid_q;
	logic adv_out, en_s1, en_s2, en_s3, count_en;

	logic signed [lcct_pkg::COORD_W-1:0] coord [lcct_pkg::MAX_DIM];
	logic signed [lcct_pkg::PROD_W-1:0]  prod_s1 [DIM];
	lcct_pkg::side_t                     side_in, side_s1, side_s3;
	logic [1:0]                          pred_s3;

	// register writes; indexes past the list, and unused weights, are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIM; i++) begin
				weight_q[i] <= '0;
			end
			bias_q   <= '0;
			margin_q <= lcct_pkg::MARGIN_RESET;
			invert_q <= 1'b0;
		end else if (wr_en) begin
			for (int i = 0; i < DIM; i++) begin
				if (wr_index == lcct_pkg::CFG_IDX_W'(int'(lcct_pkg::REG_WEIGHT_A) + i)) begin
					weight_q[i] <= $signed(wr_data[lcct_pkg::WEIGHT_W-1:0]);
				end
			end
			if (wr_index == lcct_pkg::REG_BIAS) begin
				bias_q <= $signed(wr_data[lcct_pkg::BIAS_W-1:0]);
			end
			if (wr_index == lcct_pkg::REG_MARGIN) begin
				margin_q <= wr_data[lcct_pkg::MARGIN_W-1:0];
			end
			if (wr_index == lcct_pkg::REG_INVERT) begin
				invert_q <= wr_data[0];
			end
		end
	end

	// each stage moves when it is empty or the next one moves
	assign adv_out  = !res_valid_q || res_ready;
	assign en_s3    = !v_s3 || adv_out;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign pt_ready = en_s1;
	assign count_en = v_s3 && adv_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= pt_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (adv_out) begin
				res_valid_q <= v_s3;
			end
		end
	end

	assign res_valid = res_valid_q;

	assign coord[0] = pt.coord_a;
	assign coord[1] = pt.coord_b;
	assign coord[2] = pt.coord_c;
	assign coord[3] = pt.coord_d;

	assign side_in.ground_label = pt.ground_label;
	assign side_in.first_of_set = pt.first_of_set;

	// one multiply lane per coordinate
	for (genvar g = 0; g < DIM; g++) begin : g_lane
		lcct_lane u_lane (
			.clk     (clk),
			.en      (en_s1),
			.coord   (coord[g]),
			.weight  (weight_q[g]),
			.prod_s1 (prod_s1[g])
		);
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			side_s1 <= side_in;
		end
	end

	lcct_merge #(
		.DIM (DIM)
	) u_merge (
		.clk     (clk),
		.en_s2   (en_s2),
		.en_s3   (en_s3),
		.prod_s1 (prod_s1),
		.side_s1 (side_s1),
		.bias    (bias_q),
		.margin  (margin_q),
		.invert  (invert_q),
		.pred_s3 (pred_s3),
		.side_s3 (side_s3)
	);

	lcct_tally #(
		.COUNT_BITS (COUNT_BITS)
	) u_tally (
		.clk      (clk),
		.arst_n   (arst_n),
		.count_en (count_en),
		.pred     (pred_s3),
		.side     (side_s3),
		.res_q    (res)
	);

	// a stalled input means every stage holds a point
	a_full_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!pt_ready |-> (v_s1 && v_s2 && v_s3 && res_valid_q))
		else $error("input stalled with an empty stage");

	// a result appears only from a valid compare stage
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(v_s3))
		else $error("result valid without a point in the last stage");

	// the first point of a set leaves exactly one count in the tallies
	a_first_single: assert property (@(posedge clk) disable iff (!arst_n)
		(count_en && side_s3.first_of_set) |=>
		((32'(res.error_total) + 32'(res.accurate_total)) == 32'd1))
		else $error("tallies not restarted on first point of a set");

endmodule
